>>> src/itp_pkg.sv
// Package for the integer text parser: character codes, parse phase codes,
// stream field widths, shared by the parser modules, and the digit decoder used by itp_core.
// Depends on nothing.
`default_nettype none

package itp_pkg;

	// Widths of the input item fields.
	localparam int unsigned RADIX_BITS = 5;
	localparam int unsigned CH_BITS    = 8;
	localparam int unsigned S_TDATA_BITS = ((RADIX_BITS + CH_BITS + 7) / 8) * 8;

	// Width of the emitted value field.
	localparam int unsigned OUT_VALUE_BITS = 64;

	// Character codes.
	localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
	localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
	localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
	localparam logic [7:0] CH_UF    = 8'h46;  // 'F'
	localparam logic [7:0] CH_UX    = 8'h58;  // 'X'
	localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
	localparam logic [7:0] CH_LZ    = 8'h7a;  // 'z'
	localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
	localparam logic [7:0] CH_SOH   = 8'h01;
	localparam logic [7:0] CH_PLUS  = 8'h2b;  // '+'
	localparam logic [7:0] CH_MINUS = 8'h2d;  // '-'
	localparam logic [7:0] CASE_GAP = 8'h20;  // distance between lower and upper case
	localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

	// Bases.
	localparam logic [RADIX_BITS-1:0] BASE_AUTO = 5'd0;
	localparam logic [RADIX_BITS-1:0] BASE_DEC  = 5'd10;
	localparam logic [RADIX_BITS-1:0] BASE_HEX  = 5'd16;

	// Parse phase codes.
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_LEAD   = 3'd1;
	localparam logic [2:0] PH_SIGNED = 3'd2;
	localparam logic [2:0] PH_ZERO   = 3'd3;
	localparam logic [2:0] PH_DIGITS = 3'd4;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} digit_t;

	// Fold lower-case letters onto upper case.
	function automatic logic [7:0] upper_ascii(input logic [7:0] c);
		logic [7:0] u;
		u = c;
		if (c >= CH_LA && c <= CH_LZ) begin
			u = c - CASE_GAP;
		end
		return u;
	endfunction

	// Decode an upper-cased character as a digit of base b (1..10 or 16).
	function automatic digit_t decode_digit(input logic [7:0] u,
	                                        input logic [RADIX_BITS-1:0] b);
		digit_t     d;
		logic [7:0] diff;
		d    = '0;
		diff = u - CH_ZERO;
		if (u >= CH_ZERO && u <= CH_NINE && diff < {3'b000, b}) begin
			d.ok  = 1'b1;
			d.val = diff[3:0];
		end else if (b == BASE_HEX && u >= CH_UA && u <= CH_UF) begin
			d.ok  = 1'b1;
			d.val = 4'(u - CH_UA + HEX_LETTER_BASE);
		end
		return d;
	endfunction

endpackage

`default_nettype wire

>>> src/itp_core.sv
// Parser state and next-state logic: one character is consumed per step.
// Depends on itp_pkg for character codes, phase codes and the digit decoder.
`default_nettype none

module itp_core #(
	parameter int unsigned VALUE_BITS  = 64,
	parameter int unsigned OFFSET_BITS = 10
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 step_en,
	input  wire logic                                 start_req,
	input  wire logic [itp_pkg::RADIX_BITS-1:0]       radix,
	input  wire logic [itp_pkg::CH_BITS-1:0]          ch,
	output logic                                      emit,
	output logic [itp_pkg::OUT_VALUE_BITS-1:0]        value,
	output logic [OFFSET_BITS-1:0]                    end_offset
);
	import itp_pkg::*;

	logic [2:0]              phase_q;
	logic [VALUE_BITS-1:0]   acc_q;
	logic                    neg_q;
	logic [RADIX_BITS-1:0]   base_q;
	logic [OFFSET_BITS-1:0]  cnt_q;

	logic [2:0]              phase_d;
	logic [VALUE_BITS-1:0]   acc_d;
	logic                    neg_d;
	logic [RADIX_BITS-1:0]   base_d;
	logic [OFFSET_BITS-1:0]  cnt_d;

	logic [2:0]              ph0;
	logic [VALUE_BITS-1:0]   acc0;
	logic                    neg0;
	logic [RADIX_BITS-1:0]   base0;
	logic [OFFSET_BITS-1:0]  cnt0;
	logic [OFFSET_BITS-1:0]  cnt_bump;
	logic [RADIX_BITS-1:0]   dbase;
	logic [7:0]              up;
	logic                    take_prefix;
	logic                    take_digit;
	digit_t                  dig;
	logic [VALUE_BITS-1:0]   prod;
	logic [VALUE_BITS-1:0]   signed_v;

	// A start item restarts the string, otherwise the stored state carries on.
	always_comb begin
		ph0   = start_req ? PH_LEAD : phase_q;
		acc0  = start_req ? '0 : acc_q;
		neg0  = start_req ? 1'b0 : neg_q;
		cnt0  = start_req ? '0 : cnt_q;
		if (start_req) begin
			base0 = (radix <= BASE_DEC || radix == BASE_HEX) ? radix : BASE_DEC;
		end else begin
			base0 = base_q;
		end
		cnt_bump = (cnt0 == '1) ? cnt0 : cnt0 + 1'b1;
		up       = upper_ascii(ch);
	end

	// Phase transitions, prefix handling and the digit multiply-add.
	always_comb begin
		phase_d     = ph0;
		acc_d       = acc0;
		neg_d       = neg0;
		base_d      = base0;
		cnt_d       = cnt0;
		emit        = 1'b0;
		take_prefix = 1'b0;
		take_digit  = 1'b0;
		dbase       = base0;
		dig         = '0;
		prod        = '0;

		case (ph0)
			PH_LEAD: begin
				if (ch inside {[CH_SOH:CH_SPACE]}) begin
					cnt_d = cnt_bump;
				end else if (ch == CH_PLUS || ch == CH_MINUS) begin
					neg_d   = (ch == CH_MINUS);
					cnt_d   = cnt_bump;
					phase_d = PH_SIGNED;
				end else begin
					take_prefix = 1'b1;
				end
			end
			PH_SIGNED: begin
				take_prefix = 1'b1;
			end
			PH_ZERO: begin
				if (up == CH_UX) begin
					base_d  = BASE_HEX;
					cnt_d   = cnt_bump;
					phase_d = PH_DIGITS;
				end else begin
					take_digit = 1'b1;
					dbase      = (base0 == BASE_AUTO) ? BASE_DEC : base0;
				end
			end
			PH_DIGITS: begin
				take_digit = 1'b1;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		// A leading zero may open a hex prefix in automatic or hex base.
		if (take_prefix) begin
			if ((base0 == BASE_AUTO || base0 == BASE_HEX) && ch == CH_ZERO) begin
				cnt_d   = cnt_bump;
				phase_d = PH_ZERO;
			end else begin
				take_digit = 1'b1;
				dbase      = (base0 == BASE_AUTO) ? BASE_DEC : base0;
			end
		end

		// Accumulate a digit, or end the string on the first non-digit.
		if (take_digit) begin
			base_d = dbase;
			dig    = decode_digit(up, dbase);
			prod   = acc0 * VALUE_BITS'(dbase);
			if (dig.ok) begin
				acc_d   = prod + VALUE_BITS'(dig.val);
				cnt_d   = cnt_bump;
				phase_d = PH_DIGITS;
			end else begin
				emit    = 1'b1;
				phase_d = PH_IDLE;
			end
		end
	end

	// Result value: apply the sign, then sign-extend to the output width.
	always_comb begin
		signed_v   = neg0 ? (~acc0 + 1'b1) : acc0;
		value      = OUT_VALUE_BITS'($signed(signed_v));
		end_offset = cnt0;
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			base_q  <= BASE_DEC;
			cnt_q   <= '0;
		end else if (step_en) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			base_q  <= base_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

`default_nettype wire

>>> src/integer_text_parser.sv
// Top level of the integer text parser: input register, parser core, result register.
// Depends on itp_pkg and itp_core.
`default_nettype none

// Streaming strtol-style parser. Each slave transfer carries one character; a
// transfer with tuser set starts a new string and supplies its base. Leading
// bytes 1..32 are skipped, one sign is taken, a 0x/0X prefix is honored in base
// 0 or 16, and digits accumulate modulo 2^VALUE_BITS. The first non-digit
// produces one master transfer with the signed value and the number of bytes
// consumed before it (saturating at 2^OFFSET_BITS-1); further bytes are ignored
// until the next start. Throughput is one character per cycle unless a result
// is held back by m_tready low; the multiply-add on the accumulator in the core
// is combinational. The terminating character passes through the input register
// and then the result register before m_tvalid rises. While a result waits with
// m_tready low, the held character does not advance and s_tready drops once the
// input register is occupied.
module integer_text_parser #(
	parameter int unsigned VALUE_BITS  = 64,
	parameter int unsigned OFFSET_BITS = 10
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// s_tdata: radix [4:0], ch [12:5], zero fill above
	input  wire logic [itp_pkg::S_TDATA_BITS-1:0]       s_tdata,
	// s_tuser: start_req [0]
	input  wire logic                                   s_tuser,
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// m_tdata: value [63:0], end_offset [63+OFFSET_BITS:64], zero fill above
	output logic [((64 + OFFSET_BITS + 7) / 8) * 8 - 1:0] m_tdata
);
	import itp_pkg::*;

	localparam int unsigned M_TDATA_BITS = ((OUT_VALUE_BITS + OFFSET_BITS + 7) / 8) * 8;
	localparam int unsigned M_PAD_BITS   = M_TDATA_BITS - OUT_VALUE_BITS - OFFSET_BITS;

	logic                        in_vld_s1;
	logic                        start_s1;
	logic [RADIX_BITS-1:0]       radix_s1;
	logic [CH_BITS-1:0]          ch_s1;
	logic                        advance;
	logic                        emit;
	logic [OUT_VALUE_BITS-1:0]   value;
	logic [OFFSET_BITS-1:0]      end_offset;
	logic                        out_vld_q;
	logic [OUT_VALUE_BITS-1:0]   value_q;
	logic [OFFSET_BITS-1:0]      offset_q;

	// A held character moves into the core when the result register can take it.
	assign advance  = in_vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !in_vld_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
		end else if (s_tready) begin
			in_vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			start_s1 <= s_tuser;
			radix_s1 <= s_tdata[RADIX_BITS-1:0];
			ch_s1    <= s_tdata[RADIX_BITS +: CH_BITS];
		end
	end

	// Parser state and next-state logic.
	itp_core #(
		.VALUE_BITS (VALUE_BITS),
		.OFFSET_BITS(OFFSET_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.start_req (start_s1),
		.radix     (radix_s1),
		.ch        (ch_s1),
		.emit      (emit),
		.value     (value),
		.end_offset(end_offset)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= emit;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			value_q  <= value;
			offset_q <= end_offset;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{M_PAD_BITS{1'b0}}, offset_q, value_q};

endmodule

`default_nettype wire
